/* rtl/core/rgbf_pkg.sv */
package rgbf_pkg;

	localparam int OPCODE_W   = 4;
	localparam int LEVEL_W    = 10;
	localparam int HUE_W      = 11;
	localparam int SAT_W      = 9;
	localparam int DUTY_W     = 8;
	localparam int MS_W       = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK      = 4'd0,
		OP_ON        = 4'd1,
		OP_OFF       = 4'd2,
		OP_TOGGLE    = 4'd3,
		OP_LEVEL_UP  = 4'd4,
		OP_LEVEL_DN  = 4'd5,
		OP_HUE_UP    = 4'd6,
		OP_HUE_DN    = 4'd7,
		OP_SAT_UP    = 4'd8,
		OP_SAT_DN    = 4'd9,
		OP_SET_LEVEL = 4'd10,
		OP_SET_COLOR = 4'd11
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_MS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_MS = 2'd2;

	// level*a*255/256000 == ((level*a*255) >> 11) / 125
	localparam logic [MS_W-1:0] V_DIVISOR = 16'd125;

	// 256 duty codes in, 256 gamma corrected duties out
	typedef logic [255:0][DUTY_W-1:0] gamma_lut_t;

	// Q28 power of 33: square five times, then one more product
	function automatic logic [63:0] pow33_q28(logic [63:0] y);
		logic [63:0] acc;
		acc = y;
		for (int k = 0; k < 5; k++) begin
			acc = (acc * acc) >> 28;
		end
		return (acc * y) >> 28;
	endfunction

	// Entry i of an (m+1)-entry table; every quotient found by search
	function automatic logic [DUTY_W-1:0] gamma_entry(logic [63:0] m, logic [63:0] i);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] r;
		lo = 64'd0;
		hi = 64'd1 << 28;
		for (int n = 0; n < 32; n++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (pow33_q28(mid) * m <= (i << 28))
					lo = mid;
				else
					hi = mid - 64'd1;
			end
		end
		num = 64'd255 * i * i * i * (lo >> 4);
		den = (m * m * m) << 24;
		num = num + (den >> 1);
		r = 64'd0;
		for (int b = 8; b >= 0; b--) begin
			if (((r | (64'd1 << b)) * den) <= num)
				r = r | (64'd1 << b);
		end
		return (r > 64'd255) ? 8'd255 : r[7:0];
	endfunction

	function automatic gamma_lut_t build_gamma_lut(logic [63:0] m);
		gamma_lut_t lut;
		logic [63:0] idx;
		for (int c = 0; c < 256; c++) begin
			idx = (64'(c) * m + 64'd127) / 255;
			if (idx > m)
				idx = m;
			lut[c] = gamma_entry(m, idx);
		end
		return lut;
	endfunction

endpackage

/* rtl/core/rgb_led_fader_hsv_top.sv */
// HSV LED fader with gamma correction. Events arrive as requests on the input
// channel: a 1 ms tick, on, off, toggle, level/hue/saturation steps, set level
// and set colour. Every request other than a tick is taken, leaves the input
// ready and gives no result. A tick that comes after the first on, off or
// toggle gives one result of three gamma corrected 8-bit duties (green and
// blue read zero in mono mode); a tick before that only advances the
// millisecond count. A tick runs through a sequencer that reuses the one
// multiplier and the one restoring divider: eight divide steps for the
// fade factor (skipped once the fade is complete), two products and eight
// divide steps for the value, five products and a select for the HSV sectors
// (skipped in mono mode), three gamma lookups and a final step that loads
// the output register. The input is not ready meanwhile, and longer while
// an earlier result still waits. A finished result waits in the output
// register while further events are taken. The gamma table is built at
// elaboration from GAMMA_ENTRIES (64 to 1024). Write the configuration
// registers only while the block is idle.
module rgb_led_fader_hsv_top #(
	parameter int unsigned GAMMA_ENTRIES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rgbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rgbf_pkg::OPCODE_W-1:0]   opcode,
	input  logic [rgbf_pkg::LEVEL_W-1:0]    level_value,
	input  logic [rgbf_pkg::HUE_W-1:0]      hue_value,
	input  logic [rgbf_pkg::SAT_W-1:0]      sat_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rgbf_pkg::DUTY_W-1:0]     red_duty,
	output logic [rgbf_pkg::DUTY_W-1:0]     green_duty,
	output logic [rgbf_pkg::DUTY_W-1:0]     blue_duty
);
	import rgbf_pkg::*;

	localparam gamma_lut_t GammaLut = build_gamma_lut(64'(GAMMA_ENTRIES - 1));

	typedef enum logic [3:0] {
		S_IDLE, S_FADE, S_MUL_LA, S_MUL_255, S_VDIV, S_MUL_P, S_MUL_SF,
		S_MUL_Q, S_MUL_SNF, S_MUL_T, S_SEL, S_GAM, S_DONE
	} state_t;

	state_t state_q;

	logic               color_mode_q;
	logic [MS_W-1:0]    fade_in_q;
	logic [MS_W-1:0]    fade_out_q;
	logic [LEVEL_W-1:0] level_q;
	logic [HUE_W-1:0]   hue_q;
	logic [SAT_W-1:0]   sat_q;
	logic               on_q;
	logic               started_q;
	logic [MS_W-1:0]    elapsed_q;

	logic [MS_W-1:0]    rem_q;
	logic [7:0]         dlow_q;
	logic [7:0]         quo_q;
	logic [2:0]         cnt_q;
	logic [8:0]         a_q;
	logic [17:0]        prod_q;
	logic [DUTY_W-1:0]  v_q;
	logic [DUTY_W-1:0]  p_q;
	logic [DUTY_W-1:0]  q_q;
	logic [DUTY_W-1:0]  t_q;
	logic [DUTY_W-1:0]  chan_q [3];
	logic               out_valid_q;
	logic [DUTY_W-1:0]  red_q;
	logic [DUTY_W-1:0]  green_q;
	logic [DUTY_W-1:0]  blue_q;

	// event arithmetic
	logic [LEVEL_W:0]   lvl_up;
	logic [HUE_W:0]     hue_up;
	logic [SAT_W:0]     sat_up;
	logic [MS_W-1:0]    e_new;
	logic [MS_W-1:0]    dur;

	// shared divider step
	logic [MS_W-1:0]    divisor;
	logic [MS_W:0]      shifted;
	logic [MS_W:0]      diff;
	logic               ge;
	logic [MS_W-1:0]    rem_next;
	logic [7:0]         quo_next;

	// shared multiplier
	logic [17:0]        mul_a;
	logic [16:0]        mul_b;
	logic [34:0]        mul_out;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign red_duty   = red_q;
	assign green_duty = green_q;
	assign blue_duty  = blue_q;

	always_comb begin
		lvl_up = {1'b0, level_q} + 11'd100;
		hue_up = {1'b0, hue_q} + 12'd48;
		sat_up = {1'b0, sat_q} + 10'd8;
		e_new  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
		dur    = on_q ? fade_in_q : fade_out_q;
	end

	always_comb begin
		divisor  = (state_q == S_FADE) ? dur : V_DIVISOR;
		shifted  = {rem_q, dlow_q[7]};
		diff     = shifted - {1'b0, divisor};
		ge       = (shifted >= {1'b0, divisor});
		rem_next = ge ? diff[MS_W-1:0] : shifted[MS_W-1:0];
		quo_next = {quo_q[6:0], ge};
	end

	always_comb begin
		unique case (state_q)
			S_MUL_LA: begin
				mul_a = 18'(level_q);
				mul_b = 17'(a_q);
			end
			S_MUL_255: begin
				mul_a = prod_q;
				mul_b = 17'd255;
			end
			S_MUL_P: begin
				mul_a = 18'(v_q);
				mul_b = 17'(9'd256 - sat_q);
			end
			S_MUL_SF: begin
				mul_a = 18'(sat_q);
				mul_b = 17'(hue_q[7:0]);
			end
			S_MUL_SNF: begin
				mul_a = 18'(sat_q);
				mul_b = 17'(9'd256 - {1'b0, hue_q[7:0]});
			end
			S_MUL_Q, S_MUL_T: begin
				mul_a = 18'(v_q);
				mul_b = 17'h10000 - prod_q[16:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_out = 35'(mul_a) * 35'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			color_mode_q <= 1'b1;
			fade_in_q    <= 16'd1000;
			fade_out_q   <= 16'd1500;
			level_q      <= '0;
			hue_q        <= '0;
			sat_q        <= '0;
			on_q         <= 1'b0;
			started_q    <= 1'b0;
			elapsed_q    <= '0;
			rem_q        <= '0;
			dlow_q       <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			a_q          <= '0;
			prod_q       <= '0;
			v_q          <= '0;
			p_q          <= '0;
			q_q          <= '0;
			t_q          <= '0;
			chan_q       <= '{default: '0};
			out_valid_q  <= 1'b0;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_COLOR_MODE:  color_mode_q <= cfg_data[0];
					CFG_FADE_IN_MS:  fade_in_q    <= cfg_data;
					CFG_FADE_OUT_MS: fade_out_q   <= cfg_data;
					default: ;
				endcase
			end

			// the result stage reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (op_t'(opcode))
							OP_TICK: begin
								elapsed_q <= e_new;
								if (started_q) begin
									if (e_new < dur) begin
										rem_q   <= e_new;
										dlow_q  <= '0;
										quo_q   <= '0;
										cnt_q   <= '0;
										state_q <= S_FADE;
									end else begin
										// fade complete
										a_q     <= on_q ? 9'd256 : 9'd0;
										state_q <= S_MUL_LA;
									end
								end
							end
							OP_ON, OP_OFF, OP_TOGGLE: begin
								priority if (op_t'(opcode) == OP_ON)
									on_q <= 1'b1;
								else if (op_t'(opcode) == OP_OFF)
									on_q <= 1'b0;
								else
									on_q <= !on_q;
								started_q <= 1'b1;
								elapsed_q <= '0;
							end
							OP_LEVEL_UP:
								level_q <= (lvl_up > 11'd1000) ? 10'd1000 : lvl_up[LEVEL_W-1:0];
							OP_LEVEL_DN:
								level_q <= (level_q < 10'd100) ? 10'd0 : level_q - 10'd100;
							OP_HUE_UP:
								hue_q <= (hue_up >= 12'd1536) ? 11'(hue_up - 12'd1536)
								                              : hue_up[HUE_W-1:0];
							OP_HUE_DN:
								hue_q <= (hue_q < 11'd48) ? hue_q + 11'd1488 : hue_q - 11'd48;
							OP_SAT_UP:
								sat_q <= (sat_up > 10'd256) ? 9'd256 : sat_up[SAT_W-1:0];
							OP_SAT_DN:
								sat_q <= (sat_q < 9'd8) ? 9'd0 : sat_q - 9'd8;
							OP_SET_LEVEL:
								level_q <= (level_value > 10'd1000) ? 10'd1000 : level_value;
							OP_SET_COLOR: begin
								hue_q <= (hue_value >= 11'd1536) ? hue_value - 11'd1536
								                                 : hue_value;
								sat_q <= (sat_value > 9'd256) ? 9'd256 : sat_value;
							end
							default: ;
						endcase
					end
				end
				S_FADE: begin
					// e*256/duration, one quotient bit a cycle
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					dlow_q <= {dlow_q[6:0], 1'b0};
					cnt_q  <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						a_q     <= on_q ? {1'b0, quo_next} : 9'd256 - {1'b0, quo_next};
						state_q <= S_MUL_LA;
					end
				end
				S_MUL_LA: begin
					prod_q  <= mul_out[17:0];
					state_q <= S_MUL_255;
				end
				S_MUL_255: begin
					// drop the 2^11 factor of 256000, then divide by 125
					rem_q   <= {9'd0, mul_out[25:19]};
					dlow_q  <= mul_out[18:11];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_VDIV;
				end
				S_VDIV: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					dlow_q <= {dlow_q[6:0], 1'b0};
					cnt_q  <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						v_q <= quo_next;
						if (color_mode_q) begin
							state_q <= S_MUL_P;
						end else begin
							chan_q[0] <= quo_next;
							chan_q[1] <= '0;
							chan_q[2] <= '0;
							cnt_q     <= '0;
							state_q   <= S_GAM;
						end
					end
				end
				S_MUL_P: begin
					p_q     <= mul_out[15:8];
					state_q <= S_MUL_SF;
				end
				S_MUL_SF: begin
					prod_q  <= mul_out[17:0];
					state_q <= S_MUL_Q;
				end
				S_MUL_Q: begin
					q_q     <= mul_out[23:16];
					state_q <= S_MUL_SNF;
				end
				S_MUL_SNF: begin
					prod_q  <= mul_out[17:0];
					state_q <= S_MUL_T;
				end
				S_MUL_T: begin
					t_q     <= mul_out[23:16];
					state_q <= S_SEL;
				end
				S_SEL: begin
					unique case (hue_q[10:8])
						3'd0: chan_q <= '{v_q, t_q, p_q};
						3'd1: chan_q <= '{q_q, v_q, p_q};
						3'd2: chan_q <= '{p_q, v_q, t_q};
						3'd3: chan_q <= '{p_q, q_q, v_q};
						3'd4: chan_q <= '{t_q, p_q, v_q};
						3'd5: chan_q <= '{v_q, p_q, q_q};
						default: chan_q <= '{default: '0};
					endcase
					cnt_q   <= '0;
					state_q <= S_GAM;
				end
				S_GAM: begin
					// replace each channel by its duty, one channel a cycle
					chan_q[cnt_q[1:0]] <= GammaLut[chan_q[cnt_q[1:0]]];
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd2)
						state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						red_q       <= chan_q[0];
						green_q     <= chan_q[1];
						blue_q      <= chan_q[2];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/rgbf_checker.sv */
module rgbf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [rgbf_pkg::OPCODE_W-1:0] opcode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rgbf_pkg::DUTY_W-1:0]   red_duty,
	input logic [rgbf_pkg::DUTY_W-1:0]   green_duty,
	input logic [rgbf_pkg::DUTY_W-1:0]   blue_duty
);
	import rgbf_pkg::*;

	// a waiting result holds its duties
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_duty) &&
		$stable(green_duty) && $stable(blue_duty))
		else $error("result dropped or changed while stalled");

	// any event but a tick leaves the input ready the cycle after it is taken
	a_event_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode != OP_TICK |=> in_ready)
		else $error("non-tick request left the block busy");

	// a result appears only at the end of a busy spell
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a tick being processed");

	// no result can be ready the cycle after a tick is taken
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_TICK |=> !$rose(out_valid))
		else $error("result raised too early after a tick");

endmodule

bind rgb_led_fader_hsv_top rgbf_checker u_rgbf_checker (.*);

/* test/rgb_led_fader_hsv_top_test.sv */
module rgb_led_fader_hsv_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbf_pkg::*;

	localparam int GAMMA_N     = 256;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYC  = 64;
	localparam int HOLD_CYC    = 600;
	localparam int PHASE_ITEMS = 150;
	localparam int PHASES      = 7;
	localparam int MAX_PRINTS  = 100;

	// opcodes that the block ignores
	localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd12;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;

	typedef enum int {RX_FLOW, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_t;

	typedef struct packed {
		logic [DUTY_W-1:0] red;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] blue;
	} duty_set_t;

	typedef struct {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [OPCODE_W-1:0]   op;
		logic [LEVEL_W-1:0]    lv;
		logic [HUE_W-1:0]      hv;
		logic [SAT_W-1:0]      sv;
		bit                    pinned;
		duty_set_t             pinned_duty;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [OPCODE_W-1:0]   opcode = '0;
	logic [LEVEL_W-1:0]    level_value = '0;
	logic [HUE_W-1:0]      hue_value = '0;
	logic [SAT_W-1:0]      sat_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DUTY_W-1:0]     red_duty;
	logic [DUTY_W-1:0]     green_duty;
	logic [DUTY_W-1:0]     blue_duty;

	// lamp state and register copies
	int unsigned lamp_level;
	int unsigned lamp_hue;
	int unsigned lamp_sat;
	bit          lamp_on;
	bit          lamp_started;
	int unsigned ms_since_switch;
	bit          reg_color;
	int unsigned reg_fade_in;
	int unsigned reg_fade_out;

	logic [DUTY_W-1:0] gamma_lut [GAMMA_N];
	duty_set_t         duty_due [$];
	script_row_t       script [$];
	int unsigned       burst_left = 0;
	int unsigned       errors = 0;
	int unsigned       quiet_cycles = 0;
	bit                squeeze = 1'b0;

	rgb_led_fader_hsv_top #(.GAMMA_ENTRIES(GAMMA_N)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.level_value(level_value),
		.hue_value  (hue_value),
		.sat_value  (sat_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_duty   (red_duty),
		.green_duty (green_duty),
		.blue_duty  (blue_duty)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// y^33 in Q28: five squarings give y^32, one more product
	function automatic longint unsigned q28_pow33(longint unsigned y);
		longint unsigned acc;
		acc = y;
		repeat (5) acc = (acc * acc) >> 28;
		return (acc * y) >> 28;
	endfunction

	function automatic void build_gamma_lut();
		longint unsigned m, den, tq, lo, hi, mid, num, r, i;
		m = GAMMA_N - 1;
		den = (m * m * m) << 24;
		for (i = 0; i < GAMMA_N; i++) begin
			tq = (i << 28) / m;
			lo = 0;
			hi = 64'd1 << 28;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (q28_pow33(mid) <= tq)
					lo = mid;
				else
					hi = mid - 1;
			end
			num = 64'd255 * i * i * i * (lo >> 4);
			r = (num + den / 2) / den;
			gamma_lut[i] = (r > 255) ? 8'd255 : r[7:0];
		end
	endfunction

	function automatic logic [DUTY_W-1:0] gamma_of(int unsigned c);
		int unsigned idx;
		idx = (c * (GAMMA_N - 1) + 127) / 255;
		if (idx >= GAMMA_N)
			idx = GAMMA_N - 1;
		return gamma_lut[idx];
	endfunction

	// apply one request to the lamp state; returns 1 when a tick yields duties
	function automatic bit predict_duties(input logic [OPCODE_W-1:0] op,
			input logic [LEVEL_W-1:0] lv, input logic [HUE_W-1:0] hv,
			input logic [SAT_W-1:0] sv, output duty_set_t duty);
		bit fires;
		int unsigned fade, v, s, f, p, q, t, r, g, b;
		fires = 1'b0;
		duty = '0;
		case (op)
		OP_TICK: begin
			if (ms_since_switch < 65535)
				ms_since_switch++;
			fires = lamp_started;
		end
		OP_ON, OP_OFF, OP_TOGGLE: begin
			if (op == OP_ON)
				lamp_on = 1'b1;
			else if (op == OP_OFF)
				lamp_on = 1'b0;
			else
				lamp_on = !lamp_on;
			lamp_started = 1'b1;
			ms_since_switch = 0;
		end
		OP_LEVEL_UP:  lamp_level = (lamp_level + 100 > 1000) ? 1000 : lamp_level + 100;
		OP_LEVEL_DN:  lamp_level = (lamp_level < 100) ? 0 : lamp_level - 100;
		OP_HUE_UP:    lamp_hue = (lamp_hue + 48 >= 1536) ? lamp_hue + 48 - 1536 : lamp_hue + 48;
		OP_HUE_DN:    lamp_hue = (lamp_hue < 48) ? lamp_hue + 1536 - 48 : lamp_hue - 48;
		OP_SAT_UP:    lamp_sat = (lamp_sat + 8 > 256) ? 256 : lamp_sat + 8;
		OP_SAT_DN:    lamp_sat = (lamp_sat < 8) ? 0 : lamp_sat - 8;
		OP_SET_LEVEL: lamp_level = (lv > 1000) ? 1000 : lv;
		OP_SET_COLOR: begin
			lamp_hue = (hv >= 1536) ? hv - 1536 : hv;
			lamp_sat = (sv > 256) ? 256 : sv;
		end
		default: begin
		end
		endcase
		if (fires) begin
			if (lamp_on)
				fade = (ms_since_switch < reg_fade_in) ?
					ms_since_switch * 256 / reg_fade_in : 256;
			else
				fade = (ms_since_switch < reg_fade_out) ?
					256 - ms_since_switch * 256 / reg_fade_out : 0;
			v = lamp_level * fade * 255 / 256000;
			if (v > 255)
				v = 255;
			if (!reg_color) begin
				duty = '{gamma_of(v), 8'd0, 8'd0};
			end else begin
				s = lamp_sat;
				f = lamp_hue % 256;
				p = v * (256 - s) / 256;
				q = v * (65536 - s * f) / 65536;
				t = v * (65536 - s * (256 - f)) / 65536;
				case (lamp_hue / 256)
				0:       begin r = v; g = t; b = p; end
				1:       begin r = q; g = v; b = p; end
				2:       begin r = p; g = v; b = t; end
				3:       begin r = p; g = q; b = v; end
				4:       begin r = t; g = p; b = v; end
				5:       begin r = v; g = p; b = q; end
				default: begin r = 0; g = 0; b = 0; end
				endcase
				duty = '{gamma_of(r), gamma_of(g), gamma_of(b)};
			end
		end
		return fires;
	endfunction

	function automatic void add_event(logic [OPCODE_W-1:0] op, logic [LEVEL_W-1:0] lv,
			logic [HUE_W-1:0] hv, logic [SAT_W-1:0] sv);
		script_row_t row;
		row = '{default: '0};
		row.op = op;
		row.lv = lv;
		row.hv = hv;
		row.sv = sv;
		script.push_back(row);
	endfunction

	function automatic void add_pinned_tick(logic [DUTY_W-1:0] r, logic [DUTY_W-1:0] g,
			logic [DUTY_W-1:0] b);
		script_row_t row;
		row = '{default: '0};
		row.op = OP_TICK;
		row.pinned = 1'b1;
		row.pinned_duty = '{r, g, b};
		script.push_back(row);
	endfunction

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		script_row_t row;
		row = '{default: '0};
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		script.push_back(row);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < MAX_PRINTS)
			$display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_COLOR_MODE:  reg_color = val[0];
		CFG_FADE_IN_MS:  reg_fade_in = 32'(val);
		CFG_FADE_OUT_MS: reg_fade_out = 32'(val);
		default: begin
		end
		endcase
		@(posedge clk);
	endtask

	// drop valid, drain every expected result, then let the sequencer finish
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (duty_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic offer_request(input logic [OPCODE_W-1:0] op, input logic [LEVEL_W-1:0] lv,
			input logic [HUE_W-1:0] hv, input logic [SAT_W-1:0] sv,
			input bit pinned, input duty_set_t pinned_duty);
		duty_set_t duty;
		int unsigned gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		opcode <= op;
		level_value <= lv;
		hue_value <= hv;
		sat_value <= sv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left != 0)
			burst_left--;
		if (predict_duties(op, lv, hv, sv, duty))
			duty_due.push_back(pinned ? pinned_duty : duty);
	endtask

	initial begin
		logic [OPCODE_W-1:0]   op;
		logic [LEVEL_W-1:0]    lv;
		logic [HUE_W-1:0]      hv;
		logic [SAT_W-1:0]      sv;
		logic [CFG_DATA_W-1:0] fin, fout;
		bit                    mode;
		int unsigned           pick;

		build_gamma_lut();
		lamp_level = 0;
		lamp_hue = 0;
		lamp_sat = 0;
		lamp_on = 1'b0;
		lamp_started = 1'b0;
		ms_since_switch = 0;
		reg_color = 1'b1;
		reg_fade_in = 1000;
		reg_fade_out = 1500;

		// reset values of the registers, lamp not yet switched
		add_event(OP_TICK, '0, '0, '0);
		add_event(OP_UNUSED_LO, 10'h3FF, 11'h7FF, 9'h1FF);
		add_event(OP_UNUSED_HI, '0, '0, '0);
		add_event(OP_SET_LEVEL, 10'h3FF, '0, '0);
		add_event(OP_LEVEL_UP, '0, '0, '0);
		add_event(OP_SET_COLOR, '0, 11'h7FF, 9'h1FF);
		add_event(OP_SAT_UP, '0, '0, '0);
		add_event(OP_ON, '0, '0, '0);
		// first millisecond of a long fade in is still dark
		add_pinned_tick(8'd0, 8'd0, 8'd0);
		add_write(CFG_FADE_IN_MS, 16'd0);
		add_write(CFG_FADE_OUT_MS, 16'd0);
		add_event(OP_ON, '0, '0, '0);
		add_event(OP_TICK, '0, '0, '0);
		add_event(OP_SET_COLOR, '0, 11'd0, 9'd256);
		add_pinned_tick(8'd255, 8'd0, 8'd0);
		add_event(OP_SET_COLOR, '0, 11'd1536, 9'd0);
		add_event(OP_HUE_DN, '0, '0, '0);
		add_event(OP_TICK, '0, '0, '0);
		add_event(OP_HUE_UP, '0, '0, '0);
		add_event(OP_SAT_DN, '0, '0, '0);
		add_pinned_tick(8'd255, 8'd255, 8'd255);
		add_event(OP_OFF, '0, '0, '0);
		add_pinned_tick(8'd0, 8'd0, 8'd0);
		add_event(OP_TOGGLE, '0, '0, '0);
		add_event(OP_SET_LEVEL, 10'd0, '0, '0);
		add_event(OP_LEVEL_DN, '0, '0, '0);
		add_pinned_tick(8'd0, 8'd0, 8'd0);
		add_event(OP_LEVEL_UP, '0, '0, '0);
		add_write(CFG_COLOR_MODE, 16'd0);
		add_event(OP_TICK, '0, '0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].is_write) begin
				settle();
				write_reg(script[k].reg_idx, script[k].reg_val);
			end else begin
				offer_request(script[k].op, script[k].lv, script[k].hv, script[k].sv,
					script[k].pinned, script[k].pinned_duty);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0:       begin mode = 1'b1; fin = 16'd1;     fout = 16'd1;     end
			1:       begin mode = 1'b0; fin = 16'd37;    fout = 16'd90;    end
			2:       begin mode = 1'b1; fin = 16'hFFFF;  fout = 16'hFFFF;  end
			3:       begin mode = 1'b0; fin = 16'd0;     fout = 16'd0;     end
			4: begin
				mode = 1'b1;
				fin = CFG_DATA_W'($urandom_range(1, 300));
				fout = CFG_DATA_W'($urandom_range(1, 300));
			end
			5: begin
				mode = 1'b1;
				fin = CFG_DATA_W'($urandom_range(1, 40));
				fout = CFG_DATA_W'($urandom_range(1, 40));
			end
			default: begin
				mode = 1'($urandom_range(0, 1));
				fin = CFG_DATA_W'($urandom_range(1, 120));
				fout = CFG_DATA_W'($urandom_range(1, 120));
			end
			endcase
			settle();
			write_reg(CFG_COLOR_MODE, {15'd0, mode});
			write_reg(CFG_FADE_IN_MS, fin);
			write_reg(CFG_FADE_OUT_MS, fout);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stall the receiver while a long burst keeps the input busy
				if (ph == 4 && n == 40) begin
					squeeze = 1'b1;
					burst_left = 40;
				end
				pick = $urandom_range(0, 99);
				if (pick < 50)      op = OP_TICK;
				else if (pick < 54) op = OP_ON;
				else if (pick < 58) op = OP_OFF;
				else if (pick < 62) op = OP_TOGGLE;
				else if (pick < 68) op = OP_LEVEL_UP;
				else if (pick < 72) op = OP_LEVEL_DN;
				else if (pick < 78) op = OP_HUE_UP;
				else if (pick < 82) op = OP_HUE_DN;
				else if (pick < 86) op = OP_SAT_UP;
				else if (pick < 89) op = OP_SAT_DN;
				else if (pick < 93) op = OP_SET_LEVEL;
				else if (pick < 98) op = OP_SET_COLOR;
				else                op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				lv = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom) :
					LEVEL_W'($urandom_range(0, 1000));
				hv = ($urandom_range(0, 3) == 0) ? HUE_W'($urandom) :
					HUE_W'($urandom_range(0, 1535));
				sv = ($urandom_range(0, 3) == 0) ? SAT_W'($urandom) :
					SAT_W'($urandom_range(0, 256));
				offer_request(op, lv, hv, sv, 1'b0, '0);
			end
		end

		settle();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		rx_mode_t    mode;
		int unsigned span;
		mode = RX_FLOW;
		span = 0;
		forever begin
			@(posedge clk);
			if (squeeze) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				squeeze = 1'b0;
				out_ready <= 1'b1;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(4, 80);
				end
				span--;
				case (mode)
				RX_FLOW:   out_ready <= 1'b1;
				RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		duty_set_t want;
		if (arst_n && out_valid && out_ready) begin
			if (duty_due.size() == 0) begin
				report_mismatch("result count", 1, 0);
			end else begin
				want = duty_due.pop_front();
				if (red_duty !== want.red)
					report_mismatch("red_duty", red_duty, want.red);
				if (green_duty !== want.green)
					report_mismatch("green_duty", green_duty, want.green);
				if (blue_duty !== want.blue)
					report_mismatch("blue_duty", blue_duty, want.blue);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

/* sim.f */
rtl/core/rgbf_pkg.sv
rtl/core/rgb_led_fader_hsv_top.sv
rtl/core/rgbf_checker.sv
test/rgb_led_fader_hsv_top_test.sv
